>>> design/gsm_pkg.sv
// gsm_pkg: shared constants, command and status codes and state types
// for the generational slot map; no dependencies
package gsm_pkg;
    localparam int SLOTS      = 256;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int GEN_BITS   = 16;
    localparam int DATA_WIDTH = 32;
    // slot memory word: occupied flag, generation, dense position
    localparam int SLOT_W     = 1 + GEN_BITS + IDX_W;
    // dense memory word: payload, owner
    localparam int DENSE_W    = DATA_WIDTH + IDX_W;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_KEYPOS = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_STALE = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_MOVE,
        S_DONE
    } state_t;
endpackage

>>> design/gsm_ram.sv
// gsm_ram: generic single-port synchronous ram with a registered read
// no dependencies
module gsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> design/generational_slot_map.sv
// generational_slot_map: top level, command sequencer around the slot, dense
// and free-list memories; depends on gsm_pkg and gsm_ram
//
// One command is taken at an edge where start is high and busy is low. Busy
// stays high while the command runs and the result beat on done follows in the
// next cycle, so the next command can be taken at the edge that ends the beat.
// The result cannot be held off by the receiver. The length of a command is set
// by the dependent reads of the single-port memories (slot word, then dense word
// at the hole or last position). Full and out-of-range position answers come
// from the first read state, unknown or stale keys from the second, and a remove
// that moves the last dense entry into the hole takes longest, since the mover's
// slot word is read and written back. A slot word is trusted only below the
// used-slot count, so never-used slots read as generation zero and free with
// no clearing pass and no per-slot flags.
module generational_slot_map (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic [gsm_pkg::IDX_W-1:0]     key_index,
    input  logic [gsm_pkg::GEN_BITS-1:0]  key_generation,
    input  logic [gsm_pkg::DATA_WIDTH-1:0] data_value,
    input  logic [gsm_pkg::IDX_W-1:0]     position,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [gsm_pkg::IDX_W-1:0]     result_index,
    output logic [gsm_pkg::GEN_BITS-1:0]  result_generation,
    output logic [gsm_pkg::DATA_WIDTH-1:0] result_data,
    output logic [gsm_pkg::CNT_W-1:0]     live_count
);
    import gsm_pkg::*;

    // sequencer and command registers
    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [IDX_W-1:0]      kidx_reg, kidx_next;
    logic [GEN_BITS-1:0]   kgen_reg, kgen_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    // values captured from the memories
    logic [IDX_W-1:0]      hole_reg, hole_next;
    logic [GEN_BITS-1:0]   gen_reg, gen_next;
    logic [DATA_WIDTH-1:0] mpay_reg, mpay_next;
    logic [IDX_W-1:0]      mown_reg, mown_next;

    // architectural control state
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic                  fne_reg, fne_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      used_reg, used_next;

    // output beat registers
    logic                  done_reg, done_next;
    status_t               st_reg, st_next;
    logic [IDX_W-1:0]      ridx_reg, ridx_next;
    logic [GEN_BITS-1:0]   rgen_reg, rgen_next;
    logic [DATA_WIDTH-1:0] rdat_reg, rdat_next;

    // memory ports
    logic                  s_we, d_we, f_we;
    logic [IDX_W-1:0]      s_addr, d_addr, f_addr;
    logic [SLOT_W-1:0]     s_wdata, s_rdata;
    logic [DENSE_W-1:0]    d_wdata, d_rdata;
    logic [IDX_W-1:0]      f_wdata, f_rdata;
    // slot read was below the used-slot count when issued
    logic                  s_vld_reg;

    // slot word fields
    logic                  s_occ;
    logic [GEN_BITS-1:0]   s_gen;
    logic [IDX_W-1:0]      s_pos;
    logic [IDX_W-1:0]      last_pos;

    gsm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
    );
    gsm_ram #(.WIDTH(DENSE_W), .DEPTH(SLOTS)) u_dense (
        .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
    );
    gsm_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_free (
        .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
    );

    // never-used slots read as free with generation zero
    assign s_occ    = s_vld_reg & s_rdata[SLOT_W-1];
    assign s_gen    = s_vld_reg ? s_rdata[SLOT_W-2:IDX_W] : '0;
    assign s_pos    = s_rdata[IDX_W-1:0];
    assign last_pos = IDX_W'(count_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            fne_reg   <= 1'b0;
            count_reg <= '0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fne_reg   <= fne_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        kidx_reg   <= kidx_next;
        kgen_reg   <= kgen_next;
        data_reg   <= data_next;
        pos_reg    <= pos_next;
        hole_reg   <= hole_next;
        gen_reg    <= gen_next;
        mpay_reg   <= mpay_next;
        mown_reg   <= mown_next;
        st_reg     <= st_next;
        ridx_reg   <= ridx_next;
        rgen_reg   <= rgen_next;
        rdat_reg   <= rdat_next;
        s_vld_reg  <= (CNT_W'(s_addr) < used_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        kidx_next  = kidx_reg;
        kgen_next  = kgen_reg;
        data_next  = data_reg;
        pos_next   = pos_reg;
        hole_next  = hole_reg;
        gen_next   = gen_reg;
        mpay_next  = mpay_reg;
        mown_next  = mown_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        fne_next   = fne_reg;
        count_next = count_reg;
        used_next  = used_reg;
        done_next  = 1'b0;
        st_next    = st_reg;
        ridx_next  = ridx_reg;
        rgen_next  = rgen_reg;
        rdat_next  = rdat_reg;
        s_we = 1'b0; s_addr = kidx_reg; s_wdata = '0;
        d_we = 1'b0; d_addr = pos_reg;  d_wdata = '0;
        f_we = 1'b0; f_addr = head_reg; f_wdata = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd_t'(command);
                    kidx_next  = key_index;
                    kgen_next  = key_generation;
                    data_next  = data_value;
                    pos_next   = position;
                    state_next = S_RD1;
                end
            end
            // pick the slot (insert) and issue the first read
            S_RD1:
            begin
                state_next = S_RD2;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (fne_reg)
                        begin
                            kidx_next = head_reg;
                            f_addr    = head_reg;
                        end
                        else if (used_reg < CNT_W'(SLOTS))
                        begin
                            kidx_next = IDX_W'(used_reg);
                        end
                        else
                        begin
                            st_next    = ST_FULL;
                            ridx_next  = '0;
                            rgen_next  = '0;
                            rdat_next  = '0;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_KEYPOS:
                    begin
                        d_addr = pos_reg;
                        if (CNT_W'(pos_reg) >= count_reg)
                        begin
                            st_next    = ST_RANGE;
                            ridx_next  = '0;
                            rgen_next  = '0;
                            rdat_next  = '0;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        s_addr = kidx_reg;
                    end
                endcase
            end
            // slot word (lookup/remove) or dense word (key of position) ready
            S_RD2:
            begin
                state_next = S_RD3;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        // next free head arrives now when popping the list
                        s_addr = kidx_reg;
                        if (fne_reg)
                        begin
                            if (head_reg == tail_reg)
                                fne_next = 1'b0;
                            else
                                head_next = f_rdata;
                        end
                        else
                        begin
                            used_next = used_reg + CNT_W'(1);
                        end
                        d_we    = 1'b1;
                        d_addr  = IDX_W'(count_reg);
                        d_wdata = {data_reg, kidx_reg};
                    end
                    CMD_KEYPOS:
                    begin
                        mown_next = d_rdata[IDX_W-1:0];
                        mpay_next = d_rdata[DENSE_W-1:IDX_W];
                        s_addr    = d_rdata[IDX_W-1:0];
                    end
                    default:
                    begin
                        gen_next  = s_gen;
                        hole_next = s_pos;
                        if (!s_occ || s_gen != kgen_reg)
                        begin
                            st_next    = ST_STALE;
                            ridx_next  = '0;
                            rgen_next  = '0;
                            rdat_next  = '0;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (cmd_reg == CMD_LOOKUP)
                        begin
                            d_addr = s_pos;
                        end
                        else
                        begin
                            d_addr = last_pos;
                        end
                    end
                endcase
            end
            S_RD3:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                st_next    = ST_OK;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        // generation read in last cycle; write slot word
                        s_we          = 1'b1;
                        s_addr        = kidx_reg;
                        s_wdata       = {1'b1, s_gen, IDX_W'(count_reg)};
                        count_next    = count_reg + CNT_W'(1);
                        ridx_next     = kidx_reg;
                        rgen_next     = s_gen;
                        rdat_next     = '0;
                    end
                    CMD_LOOKUP:
                    begin
                        ridx_next = kidx_reg;
                        rgen_next = gen_reg;
                        rdat_next = d_rdata[DENSE_W-1:IDX_W];
                    end
                    CMD_KEYPOS:
                    begin
                        ridx_next = mown_reg;
                        rgen_next = s_gen;
                        rdat_next = mpay_reg;
                    end
                    default:
                    begin
                        // remove: last dense entry ready, fill the hole
                        mpay_next = d_rdata[DENSE_W-1:IDX_W];
                        mown_next = d_rdata[IDX_W-1:0];
                        s_we      = 1'b1;
                        s_addr    = kidx_reg;
                        s_wdata   = {1'b0, GEN_BITS'(gen_reg + GEN_BITS'(1)), hole_reg};
                        if (fne_reg)
                        begin
                            f_we    = 1'b1;
                            f_addr  = tail_reg;
                            f_wdata = kidx_reg;
                        end
                        else
                        begin
                            head_next = kidx_reg;
                            fne_next  = 1'b1;
                        end
                        tail_next  = kidx_reg;
                        d_we       = (hole_reg != last_pos);
                        d_addr     = hole_reg;
                        d_wdata    = d_rdata;
                        ridx_next  = kidx_reg;
                        rgen_next  = gen_reg;
                        rdat_next  = '0;
                        if (hole_reg != last_pos)
                        begin
                            done_next  = 1'b0;
                            state_next = S_MOVE;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                endcase
            end
            // remove: fetch the moved slot's word
            S_MOVE:
            begin
                s_addr     = mown_reg;
                state_next = S_DONE;
            end
            // remove: point the moved slot at the hole
            S_DONE:
            begin
                s_we       = 1'b1;
                s_addr     = mown_reg;
                // mover is live, so its word was written
                s_wdata    = {s_rdata[SLOT_W-1:IDX_W], hole_reg};
                count_next = count_reg - CNT_W'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign status            = st_reg;
    assign result_index      = ridx_reg;
    assign result_generation = rgen_reg;
    assign result_data       = rdat_reg;
    assign live_count        = count_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS)) else $error("live count above capacity");
    a_count_used: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= used_reg) else $error("live count above used slots");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
endmodule

>>> tb/gsm_checker.sv
// gsm_checker: watches command and result beats of the generational slot map,
// predicts each result from its own copy of the table and compares; uses gsm_pkg
module gsm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [1:0]                     command,
    input  logic [gsm_pkg::IDX_W-1:0]      key_index,
    input  logic [gsm_pkg::GEN_BITS-1:0]   key_generation,
    input  logic [gsm_pkg::DATA_WIDTH-1:0] data_value,
    input  logic [gsm_pkg::IDX_W-1:0]      position,
    input  logic                           done,
    input  logic [1:0]                     status,
    input  logic [gsm_pkg::IDX_W-1:0]      result_index,
    input  logic [gsm_pkg::GEN_BITS-1:0]   result_generation,
    input  logic [gsm_pkg::DATA_WIDTH-1:0] result_data,
    input  logic [gsm_pkg::CNT_W-1:0]      live_count,
    output int                             fail_count,
    output int                             pending,
    output int                             results_seen
);
    import gsm_pkg::*;

    typedef struct packed {
        status_t                 st;
        logic [IDX_W-1:0]        idx;
        logic [GEN_BITS-1:0]     gen;
        logic [DATA_WIDTH-1:0]   data;
        logic [CNT_W-1:0]        cnt;
    } answer_t;

    logic [GEN_BITS-1:0]   gen_of   [SLOTS];
    logic                  occupied [SLOTS];
    logic [IDX_W-1:0]      dense_at [SLOTS];
    logic [IDX_W-1:0]      next_free[SLOTS];
    logic [DATA_WIDTH-1:0] payload  [SLOTS];
    logic [IDX_W-1:0]      owner    [SLOTS];
    logic [IDX_W-1:0]      fl_head, fl_tail;
    logic                  fl_any;
    int                    live, used;
    answer_t               answers_due[$];

    function automatic answer_t mk(status_t s, logic [IDX_W-1:0] i,
            logic [GEN_BITS-1:0] g, logic [DATA_WIDTH-1:0] d);
        answer_t a;
        a.st = s; a.idx = i; a.gen = g; a.data = d; a.cnt = CNT_W'(live);
        return a;
    endfunction

    // apply one command to the shadow table and return its answer
    function automatic answer_t apply_command(cmd_t c, logic [IDX_W-1:0] ki,
            logic [GEN_BITS-1:0] kg, logic [DATA_WIDTH-1:0] dv, logic [IDX_W-1:0] ps);
        logic [IDX_W-1:0] slot, hole, last, mover;
        logic [GEN_BITS-1:0] g;
        case (c)
            CMD_INSERT:
            begin
                if (fl_any)
                begin
                    slot = fl_head;
                    if (fl_head == fl_tail) fl_any = 0;
                    else fl_head = next_free[slot];
                end
                else if (used < SLOTS)
                begin
                    slot = IDX_W'(used);
                    used++;
                end
                else
                    return mk(ST_FULL, '0, '0, '0);
                payload[live] = dv;
                owner[live] = slot;
                dense_at[slot] = IDX_W'(live);
                occupied[slot] = 1;
                live++;
                return mk(ST_OK, slot, gen_of[slot], '0);
            end
            CMD_LOOKUP:
            begin
                if (!occupied[ki] || gen_of[ki] != kg) return mk(ST_STALE, '0, '0, '0);
                return mk(ST_OK, ki, gen_of[ki], payload[dense_at[ki]]);
            end
            CMD_REMOVE:
            begin
                if (!occupied[ki] || gen_of[ki] != kg) return mk(ST_STALE, '0, '0, '0);
                g = gen_of[ki];
                gen_of[ki] = g + 1'b1;
                if (fl_any) next_free[fl_tail] = ki;
                else
                begin
                    fl_head = ki;
                    fl_any = 1;
                end
                fl_tail = ki;
                hole = dense_at[ki];
                last = IDX_W'(live - 1);
                if (hole != last)
                begin
                    mover = owner[last];
                    payload[hole] = payload[last];
                    owner[hole] = mover;
                    dense_at[mover] = hole;
                end
                occupied[ki] = 0;
                live--;
                return mk(ST_OK, ki, g, '0);
            end
            default:
            begin
                if (ps >= live) return mk(ST_RANGE, '0, '0, '0);
                return mk(ST_OK, owner[ps], gen_of[owner[ps]], payload[ps]);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t got, want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                gen_of[i] = 0;
                occupied[i] = 0;
            end
            fl_head = 0; fl_tail = 0; fl_any = 0; live = 0; used = 0;
            answers_due.delete();
            fail_count = 0; pending = 0; results_seen = 0;
        end
        else
        begin
            // results first: a command taken this edge cannot finish this edge
            if (done)
            begin
                got = '{status_t'(status), result_index, result_generation,
                        result_data, live_count};
                results_seen++;
                if (answers_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result beat %p", got);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (start && !busy)
                answers_due.push_back(apply_command(cmd_t'(command), key_index,
                                                    key_generation, data_value, position));
            pending = answers_due.size();
        end
    end
endmodule

>>> tb/tb_generational_slot_map.sv
// tb_generational_slot_map: stimulus and verdict for the generational slot map;
// depends on gsm_pkg, generational_slot_map and gsm_checker
module tb_generational_slot_map;
    import gsm_pkg::*;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  start = 0;
    logic [1:0]            command = CMD_INSERT;
    logic [IDX_W-1:0]      key_index = 0;
    logic [GEN_BITS-1:0]   key_generation = 0;
    logic [DATA_WIDTH-1:0] data_value = 0;
    logic [IDX_W-1:0]      position = 0;
    logic                  busy, done;
    logic [1:0]            status;
    logic [IDX_W-1:0]      result_index;
    logic [GEN_BITS-1:0]   result_generation;
    logic [DATA_WIDTH-1:0] result_data;
    logic [CNT_W-1:0]      live_count;
    int                    fail_count, pending, results_seen;

    // keys handed out by the block, kept so lookups and removes hit live slots
    logic [IDX_W-1:0]      key_idx_pool[$];
    logic [GEN_BITS-1:0]   key_gen_pool[$];
    int                    sent;
    int                    gap_pct;

    always #2 clk = ~clk;

    generational_slot_map dut (.*);

    gsm_checker checker_i (.*);

    // harvest keys from OK results with zero data: inserts, but also removes and zero lookups
    always @(posedge clk)
        if (done && status == ST_OK && result_data == 0 && live_count != 0
            && key_idx_pool.size() < 400)
        begin
            key_idx_pool.push_back(result_index);
            key_gen_pool.push_back(result_generation);
        end

    // one command beat: optional idle gap, then hold start to the accepting edge
    task automatic send(cmd_t c, logic [IDX_W-1:0] ki, logic [GEN_BITS-1:0] kg,
                        logic [DATA_WIDTH-1:0] dv, logic [IDX_W-1:0] ps);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 0;
            @(posedge clk);
            while ($urandom_range(99) < gap_pct) @(posedge clk);
        end
        command <= c;
        key_index <= ki;
        key_generation <= kg;
        data_value <= dv;
        position <= ps;
        start <= 1;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent++;
    endtask

    // pick a key: mostly a harvested one, sometimes stale or random
    task automatic send_keyed(cmd_t c);
        int k;
        logic [IDX_W-1:0] ki;
        logic [GEN_BITS-1:0] kg;
        ki = IDX_W'($urandom);
        kg = GEN_BITS'($urandom);
        if (key_idx_pool.size() != 0 && $urandom_range(9) < 8)
        begin
            k = $urandom_range(key_idx_pool.size() - 1);
            ki = key_idx_pool[k];
            kg = key_gen_pool[k];
            if ($urandom_range(9) == 0) kg = kg + 1'b1;
        end
        send(c, ki, kg, DATA_WIDTH'($urandom), IDX_W'($urandom));
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        int roll;
        sent = 0;
        gap_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty-table corners, field extremes, reuse of a freed slot
        send(CMD_LOOKUP, 0, 0, 0, 0);
        send(CMD_REMOVE, 8'hff, 16'hffff, 0, 0);
        send(CMD_KEYPOS, 0, 0, 0, 0);
        send(CMD_INSERT, 0, 0, 32'hffff_ffff, 0);
        send(CMD_INSERT, 0, 0, 32'h0, 0);
        send(CMD_KEYPOS, 0, 0, 0, 8'd1);
        send(CMD_KEYPOS, 0, 0, 0, 8'd2);
        send(CMD_KEYPOS, 0, 0, 0, 8'hff);
        send(CMD_LOOKUP, 8'd1, 0, 0, 0);
        send(CMD_LOOKUP, 8'd1, 16'hffff, 0, 0);
        send(CMD_REMOVE, 8'd0, 0, 0, 0);   // hole filled from the last entry
        send(CMD_KEYPOS, 0, 0, 0, 0);
        send(CMD_REMOVE, 8'd0, 0, 0, 0);   // stale now
        send(CMD_INSERT, 0, 0, 32'h1234_5678, 0); // reuses slot 0, generation 1
        send(CMD_LOOKUP, 8'd0, 16'd1, 0, 0);
        drain();

        // fill to capacity, then full status
        while (sent < 300)
            send(CMD_INSERT, 0, 0, DATA_WIDTH'($urandom), 0);
        send(CMD_INSERT, 0, 0, DATA_WIDTH'($urandom), 0);
        send(CMD_KEYPOS, 0, 0, 0, 8'hff);
        drain();   // sender holds off until every result is back

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++)
        begin
            gap_pct = (ph == 0) ? 0 : (ph == 1) ? 77 : (ph == 2) ? 0 : 12;
            repeat (160)
            begin
                roll = $urandom_range(99);
                if (roll < 30)
                    send(CMD_INSERT, IDX_W'($urandom), GEN_BITS'($urandom),
                         DATA_WIDTH'($urandom), IDX_W'($urandom));
                else if (roll < 55) send_keyed(CMD_LOOKUP);
                else if (roll < 85) send_keyed(CMD_REMOVE);
                else send(CMD_KEYPOS, IDX_W'($urandom), GEN_BITS'($urandom),
                          DATA_WIDTH'($urandom), IDX_W'($urandom_range(live_count + 2)));
            end
        end
        drain();

        // insert and then remove one key at a time, stepping the generations of freed slots
        gap_pct = 0;
        repeat (25)
        begin
            key_idx_pool.delete();
            key_gen_pool.delete();
            send(CMD_INSERT, 0, 0, DATA_WIDTH'($urandom), 0);
            drain();
            @(posedge clk);
            if (key_idx_pool.size() != 0) send_keyed(CMD_REMOVE);
        end
        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d commands with %0d checked results: fill to full,", sent,
                 results_seen);
        $display("stale keys, dense moves on remove, position range and idle phases");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
